// File: hw/rtl/pcg_pkg.sv
// Shared types, constants and the sine table function for the pixel correction core.
package pcg_pkg;

  // Measure-pass accumulator sizes and the count limit.
  localparam int unsigned SUM_W      = 41;
  localparam int unsigned COUNT_W    = 25;
  localparam int unsigned MAX_PIXELS = 16777216;

  // Configuration port sizes.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CONTRAST_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTRAST_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS_OFF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA_ENABLE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA_STEP_CH0   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA_STEP_CH12  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAYSCALE_ENABLE = 3'd6;

  // Operation codes of an input item.
  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_CORRECT = 1'b1;

  // Reset value of the contrast gain (close to unity).
  localparam logic signed [10:0] GAIN_RESET = 11'sd255;

  // Fixed-point constants for building the sine table.
  localparam logic [63:0] Q30_PI      = 64'd3373259426;
  localparam logic [63:0] Q30_HALF_PI = Q30_PI / 2;
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

  // Reciprocal of three for the grayscale average (x * 683 >> 11).
  localparam logic [10:0] THIRD_MUL = 11'd683;

  typedef struct packed {
    logic       op;
    logic       frame_start;
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out0;
    logic [7:0] out1;
    logic [7:0] out2;
  } out_item_t;

  // Live configuration; gamma steps are kept premultiplied by ten.
  typedef struct packed {
    logic               contrast_enable;
    logic signed [10:0] gain;
    logic signed [8:0]  offset;
    logic               gamma_enable;
    logic signed [11:0] step10_ch0;
    logic signed [11:0] step10_ch12;
    logic               gray_enable;
  } cfg_t;

  // Saturate a signed value to the 0..255 pixel range.
  function automatic logic [7:0] clamp8(input logic signed [13:0] a);
    logic [7:0] res;
    if (a < 14'sd0) begin
      res = 8'd0;
    end else if (a > 14'sd255) begin
      res = 8'd255;
    end else begin
      res = a[7:0];
    end
    return res;
  endfunction

  // One sine table entry: round(sin(v * 0.01255) * 65536) in signed Q1.16.
  // Evaluated with constant arguments only, so it folds into a table.
  function automatic logic signed [17:0] sine_entry(input logic [7:0] v);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] mag;
    logic [17:0] m18;
    logic        neg;
    x = (((64'(v) * 64'd1255) << 30) + 64'd50000) / 64'd100000;
    if (x <= Q30_PI) begin
      r   = Q30_PI - x;
      neg = 1'b0;
    end else begin
      r   = x - Q30_PI;
      neg = 1'b1;
    end
    if (r > Q30_HALF_PI) begin
      r = Q30_PI - r;
    end
    x2 = (r * r) >> 30;
    // Nested Taylor series, innermost term first.
    t = Q30_ONE;
    t = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
    t = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
    t = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s   = (r * t) >> 30;
    mag = (s + (64'd1 << 13)) >> 14;
    m18 = mag[17:0];
    return neg ? $signed(-m18) : $signed(m18);
  endfunction

endpackage

// File: hw/rtl/pcg_mean.sv
// Luma accumulator for the measure pass and the serial mean divider.
module pcg_mean (
  input  logic       clk,
  input  logic       rst,
  input  logic       measure,
  input  logic       frame_start,
  input  logic [7:0] chan0,
  input  logic [7:0] chan1,
  input  logic [7:0] chan2,
  output logic [7:0] mean,
  output logic       ready
);

  logic [pcg_pkg::SUM_W-1:0]   sum;
  logic [pcg_pkg::COUNT_W-1:0] count;
  logic                        dirty;
  logic                        busy;
  logic [pcg_pkg::SUM_W-1:0]   rem;
  logic [pcg_pkg::SUM_W-1:0]   dvs;
  logic [6:0]                  quo;
  logic [2:0]                  step;

  logic [15:0]                 luma;
  logic [pcg_pkg::SUM_W-1:0]   base_sum;
  logic [pcg_pkg::COUNT_W-1:0] base_cnt;
  logic                        ge;

  // Weighted luma of one pixel and the frame-start clear.
  assign luma = 16'd77 * 16'(chan0) + 16'd150 * 16'(chan1) + 16'd29 * 16'(chan2);
  assign base_sum = frame_start ? '0 : sum;
  assign base_cnt = frame_start ? '0 : count;
  assign ge = (rem >= dvs);

  assign ready = !dirty && !busy;

  // Accumulate on measure items; otherwise refresh the mean one quotient bit per cycle.
  // A measure item during a division aborts it and a fresh division follows.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      count <= '0;
      dirty <= 1'b0;
      busy  <= 1'b0;
      mean  <= 8'd0;
      rem   <= '0;
      dvs   <= '0;
      quo   <= '0;
      step  <= '0;
    end else if (measure) begin
      if (base_cnt < pcg_pkg::COUNT_W'(pcg_pkg::MAX_PIXELS)) begin
        sum   <= base_sum + pcg_pkg::SUM_W'(luma);
        count <= base_cnt + 1'b1;
      end else begin
        sum   <= base_sum;
        count <= base_cnt;
      end
      dirty <= 1'b1;
      busy  <= 1'b0;
    end else if (dirty) begin
      dirty <= 1'b0;
      if (count == '0) begin
        mean <= 8'd0;
      end else begin
        busy <= 1'b1;
        rem  <= sum;
        // Divisor is 256 * count, aligned to the top quotient bit.
        dvs  <= pcg_pkg::SUM_W'(count) << 15;
        quo  <= '0;
        step <= 3'd7;
      end
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dvs;
      end
      quo <= {quo[5:0], ge};
      dvs <= dvs >> 1;
      if (step == 3'd0) begin
        busy <= 1'b0;
        mean <= {quo, ge};
      end else begin
        step <= step - 3'd1;
      end
    end
  end

endmodule

// File: hw/rtl/pcg_lane.sv
// One channel lane: contrast stretch and sine gamma over five pipeline stages.
module pcg_lane (
  input  logic               clk,
  input  logic               adv,
  input  logic [7:0]         chan,
  input  logic [7:0]         mean,
  input  pcg_pkg::cfg_t      cfg,
  input  logic signed [11:0] step10,
  output logic [7:0]         result
);

  logic signed [17:0] rom [256];

  logic signed [8:0]  diff;
  logic signed [19:0] prod1;
  logic [7:0]         orig1;
  logic [7:0]         mean1;
  logic signed [13:0] sum2;
  logic [7:0]         val2;
  logic signed [17:0] sin3;
  logic [7:0]         val3;
  logic signed [29:0] prod4;
  logic [7:0]         val4;
  logic signed [13:0] sum5;

  // Sine table, folded to constants at elaboration.
  for (genvar g = 0; g < 256; g++) begin : g_rom
    assign rom[g] = pcg_pkg::sine_entry(8'(g));
  end

  assign diff = $signed({1'b0, chan}) - $signed({1'b0, mean});

  // Contrast sum: floored product plus mean and brightness offset.
  assign sum2 = 14'($signed(prod1[19:8])) + $signed({6'd0, mean1}) + 14'(cfg.offset);

  // Gamma sum: floored correction plus the pixel value.
  assign sum5 = 14'(prod4[29:16]) + $signed({6'd0, val4});

  // Stage 1 multiplies, 2 saturates, 3 reads the table, 4 multiplies, 5 saturates.
  always_ff @(posedge clk) begin
    if (adv) begin
      prod1  <= diff * cfg.gain;
      orig1  <= chan;
      mean1  <= mean;
      val2   <= cfg.contrast_enable ? pcg_pkg::clamp8(sum2) : orig1;
      sin3   <= rom[val2];
      val3   <= val2;
      prod4  <= sin3 * step10;
      val4   <= val3;
      result <= cfg.gamma_enable ? pcg_pkg::clamp8(sum5) : val4;
    end
  end

endmodule

// File: hw/rtl/pcg_merge.sv
// Merge stage: optional grayscale average of the three lanes into the output register.
module pcg_merge (
  input  logic               clk,
  input  logic               adv,
  input  logic               gray_enable,
  input  logic [7:0]         lane0,
  input  logic [7:0]         lane1,
  input  logic [7:0]         lane2,
  output pcg_pkg::out_item_t out_data
);

  logic [9:0]  total;
  logic [20:0] scaled;
  logic [7:0]  avg;

  // Floored division by three through a reciprocal multiply.
  assign total  = 10'(lane0) + 10'(lane1) + 10'(lane2);
  assign scaled = 21'(total) * 21'(pcg_pkg::THIRD_MUL);
  assign avg    = scaled[18:11];

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.out0 <= gray_enable ? avg : lane0;
      out_data.out1 <= gray_enable ? avg : lane1;
      out_data.out2 <= gray_enable ? avg : lane2;
    end
  end

endmodule

// File: hw/rtl/pixel_contrast_gamma_gray_core.sv
// Pixel correction core: measure pass builds the mean, correct pass yields one item per pixel.
// A correct item passes the lane stages and the merge output register. The core takes one
// item per cycle, measure or correct; correct items wait while the output register is stalled.
// After the last measure item the 8-step serial mean divider holds off correct items while
// it loads and runs its eight quotient steps. Measure items give no result.
// Synchronous reset clears the accumulator, the pipeline valids and the settings (gain 255).
module pixel_contrast_gamma_gray_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  pcg_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output pcg_pkg::out_item_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pcg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcg_pkg::CFG_DATA_W-1:0]   cfg_data
);

  pcg_pkg::cfg_t      cfg;
  logic [4:0]         vld;
  logic               adv;
  logic               in_fire;
  logic               measure;
  logic               correct;
  logic [7:0]         mean;
  logic               mean_ready;
  logic [7:0]         lane0;
  logic [7:0]         lane1;
  logic [7:0]         lane2;
  logic signed [11:0] step_a;
  logic signed [11:0] step_b;

  // The pipeline moves whenever the output register is free or being taken.
  assign adv       = !out_valid || !out_stall;
  assign in_stall  = (in_data.op == pcg_pkg::OP_CORRECT) ? (!adv || !mean_ready) : 1'b0;
  assign in_fire   = in_valid && !in_stall;
  assign measure   = in_fire && (in_data.op == pcg_pkg::OP_MEASURE);
  assign correct   = in_fire && (in_data.op == pcg_pkg::OP_CORRECT);
  assign cfg_ready = 1'b1;

  // Gamma steps scaled by ten at write time.
  assign step_a = ($signed(12'(signed'(cfg_data[7:0]))) <<< 3)
                + ($signed(12'(signed'(cfg_data[7:0]))) <<< 1);
  assign step_b = ($signed(12'(signed'(cfg_data[6:0]))) <<< 3)
                + ($signed(12'(signed'(cfg_data[6:0]))) <<< 1);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.contrast_enable <= 1'b0;
      cfg.gain            <= pcg_pkg::GAIN_RESET;
      cfg.offset          <= '0;
      cfg.gamma_enable    <= 1'b0;
      cfg.step10_ch0      <= '0;
      cfg.step10_ch12     <= '0;
      cfg.gray_enable     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pcg_pkg::CFG_CONTRAST_ENABLE:  cfg.contrast_enable <= cfg_data[0];
        pcg_pkg::CFG_CONTRAST_GAIN:    cfg.gain            <= $signed(cfg_data[10:0]);
        pcg_pkg::CFG_BRIGHTNESS_OFF:   cfg.offset          <= $signed(cfg_data[8:0]);
        pcg_pkg::CFG_GAMMA_ENABLE:     cfg.gamma_enable    <= cfg_data[0];
        pcg_pkg::CFG_GAMMA_STEP_CH0:   cfg.step10_ch0      <= step_a;
        pcg_pkg::CFG_GAMMA_STEP_CH12:  cfg.step10_ch12     <= step_b;
        pcg_pkg::CFG_GRAYSCALE_ENABLE: cfg.gray_enable     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Valid bits of the five lane stages and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[3:0], correct};
      out_valid <= vld[4];
    end
  end

  pcg_mean u_mean (
    .clk         (clk),
    .rst         (rst),
    .measure     (measure),
    .frame_start (in_data.frame_start),
    .chan0       (in_data.chan0),
    .chan1       (in_data.chan1),
    .chan2       (in_data.chan2),
    .mean        (mean),
    .ready       (mean_ready)
  );

  pcg_lane u_lane0 (
    .clk    (clk),
    .adv    (adv),
    .chan   (in_data.chan0),
    .mean   (mean),
    .cfg    (cfg),
    .step10 (cfg.step10_ch0),
    .result (lane0)
  );

  pcg_lane u_lane1 (
    .clk    (clk),
    .adv    (adv),
    .chan   (in_data.chan1),
    .mean   (mean),
    .cfg    (cfg),
    .step10 (cfg.step10_ch12),
    .result (lane1)
  );

  pcg_lane u_lane2 (
    .clk    (clk),
    .adv    (adv),
    .chan   (in_data.chan2),
    .mean   (mean),
    .cfg    (cfg),
    .step10 (cfg.step10_ch12),
    .result (lane2)
  );

  pcg_merge u_merge (
    .clk         (clk),
    .adv         (adv),
    .gray_enable (cfg.gray_enable),
    .lane0       (lane0),
    .lane1       (lane1),
    .lane2       (lane2),
    .out_data    (out_data)
  );

endmodule

// File: tb/pcg_result_checker.sv
// Result checker for the pixel correction core: predicts each corrected pixel and compares it.
module pcg_result_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  pcg_pkg::in_item_t              in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  pcg_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [pcg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcg_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending_results,
  output int                             results_checked
);
  import pcg_pkg::*;

  // Luma weights of the three byte positions.
  localparam int LUMA_W0 = 77;
  localparam int LUMA_W1 = 150;
  localparam int LUMA_W2 = 29;

  // Fixed-point angle constants for the sine table.
  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  // Mirrored settings and measure-pass state.
  logic            contrast_on;
  int              gain;
  int              offset;
  logic            gamma_on;
  int              step_c0;
  int              step_c12;
  logic            gray_on;
  longint unsigned acc_sum;
  longint unsigned acc_count;

  int        sine_q16 [256];
  out_item_t expected_pixels [$];
  out_item_t want;
  int        fail_tally;
  int        checked;

  // Signed Q1.16 sine of v*0.01255, built from a Q30 angle and a nested Taylor series.
  function automatic int sine_q16_entry(int unsigned v);
    longint unsigned ang;
    longint unsigned red;
    longint unsigned sq;
    longint unsigned poly;
    longint unsigned div;
    longint unsigned mag;
    bit              neg;
    ang = (((longint'(v) * 1255) << 30) + 50000) / 100000;
    neg = (ang > PI_Q30);
    red = neg ? ang - PI_Q30 : PI_Q30 - ang;
    if (red > PI_Q30 / 2) begin
      red = PI_Q30 - red;
    end
    sq   = (red * red) >> 30;
    poly = ONE_Q30;
    for (int k = 0; k < 6; k++) begin
      case (k)
        0: div = 156;
        1: div = 110;
        2: div = 72;
        3: div = 42;
        4: div = 20;
        default: div = 6;
      endcase
      poly = ONE_Q30 - ((sq * poly) >> 30) / div;
    end
    mag = (((red * poly) >> 30) + (64'd1 << 13)) >> 14;
    return neg ? -int'(mag) : int'(mag);
  endfunction

  function automatic int clamp_byte(longint a);
    return (a < 0) ? 0 : ((a > 255) ? 255 : int'(a));
  endfunction

  // Expected output of one correct item under the current settings and mean.
  function automatic out_item_t corrected_pixel(in_item_t px);
    int        ch [3];
    int        mean;
    int        step;
    longint    lift;
    out_item_t res;
    ch[0] = px.chan0;
    ch[1] = px.chan1;
    ch[2] = px.chan2;
    mean  = (acc_count == 0) ? 0 : int'(acc_sum / (256 * acc_count));
    if (contrast_on) begin
      for (int k = 0; k < 3; k++) begin
        ch[k] = clamp_byte(longint'(((ch[k] - mean) * gain) >>> 8) + mean + offset);
      end
    end
    if (gamma_on) begin
      for (int k = 0; k < 3; k++) begin
        step  = (k == 0) ? step_c0 : step_c12;
        lift  = longint'(sine_q16[ch[k]]) * step * 10;
        ch[k] = clamp_byte(ch[k] + (lift >>> 16));
      end
    end
    if (gray_on) begin
      ch[0] = (ch[0] + ch[1] + ch[2]) / 3;
      ch[1] = ch[0];
      ch[2] = ch[0];
    end
    res.out0 = ch[0][7:0];
    res.out1 = ch[1][7:0];
    res.out2 = ch[2][7:0];
    return res;
  endfunction

  task automatic note_failure(string msg);
    fail_tally++;
    if (fail_tally <= 10) begin
      $display("%s", msg);
    end
  endtask

  initial begin
    for (int v = 0; v < 256; v++) begin
      sine_q16[v] = sine_q16_entry(v);
    end
  end

  // All three channels are sampled at the clock edge; results are checked before new
  // items are queued so that a stray result never matches a fresh expectation.
  always @(posedge clk) begin
    if (rst) begin
      contrast_on = 1'b0;
      gain        = int'(GAIN_RESET);
      offset      = 0;
      gamma_on    = 1'b0;
      step_c0     = 0;
      step_c12    = 0;
      gray_on     = 1'b0;
      acc_sum     = 0;
      acc_count   = 0;
      expected_pixels.delete();
      fail_tally  = 0;
      checked     = 0;
    end else begin
      // Compare a delivered item with the oldest expectation.
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          note_failure($sformatf("unexpected result %0d %0d %0d",
                                 out_data.out0, out_data.out1, out_data.out2));
        end else begin
          want = expected_pixels.pop_front();
          checked++;
          if (want.out0 !== out_data.out0 || want.out1 !== out_data.out1 ||
              want.out2 !== out_data.out2) begin
            note_failure($sformatf("mismatch on result %0d: expected %0d %0d %0d, got %0d %0d %0d",
                                   checked, want.out0, want.out1, want.out2,
                                   out_data.out0, out_data.out1, out_data.out2));
          end
        end
      end

      // Track register writes; an index past the list changes nothing.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CONTRAST_ENABLE:  contrast_on = cfg_data[0];
          CFG_CONTRAST_GAIN:    gain        = int'($signed(cfg_data));
          CFG_BRIGHTNESS_OFF:   offset      = int'($signed(cfg_data[8:0]));
          CFG_GAMMA_ENABLE:     gamma_on    = cfg_data[0];
          CFG_GAMMA_STEP_CH0:   step_c0     = int'($signed(cfg_data[7:0]));
          CFG_GAMMA_STEP_CH12:  step_c12    = int'($signed(cfg_data[6:0]));
          CFG_GRAYSCALE_ENABLE: gray_on     = cfg_data[0];
          default: ;
        endcase
      end

      // Accepted input: queue a prediction or update the measure state.
      if (in_valid && !in_stall) begin
        if (in_data.op == OP_CORRECT) begin
          expected_pixels.push_back(corrected_pixel(in_data));
        end else begin
          if (in_data.frame_start) begin
            acc_sum   = 0;
            acc_count = 0;
          end
          if (acc_count < MAX_PIXELS) begin
            acc_sum += LUMA_W0 * in_data.chan0 + LUMA_W1 * in_data.chan1 +
                       LUMA_W2 * in_data.chan2;
            acc_count++;
          end
        end
      end
    end
    fail_count      <= fail_tally;
    pending_results <= expected_pixels.size();
    results_checked <= checked;
  end

endmodule

// File: tb/testbench.sv
// Top of the pixel correction testbench: clock, reset, stimulus, stall control and verdict.
module testbench;
  import pcg_pkg::*;

  // Settle time after the last result covers the mean divider and the pipeline.
  localparam int SETTLE_CYCLES  = 24;
  localparam int HOLD_CYCLES    = 120;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int fail_count;
  int pending_results;
  int results_checked;

  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_req  = 0;
  int hold_seen;
  int hold_left;
  int quiet_cycles;
  int n_measure = 0;
  int n_correct = 0;
  int n_cfg     = 0;

  always #5 clk = ~clk;

  pixel_contrast_gamma_gray_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pcg_result_checker pixel_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .results_checked (results_checked)
  );

  // Receiver: random stalls, or a long hold whenever a new one is requested.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: too long without any accepted item on any channel ends the run.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Mostly random bytes, with the two extremes showing up often.
  function automatic logic [7:0] rand_byte();
    int pick;
    pick = $urandom_range(7);
    if (pick == 0) begin
      return 8'd0;
    end else if (pick == 1) begin
      return 8'd255;
    end
    return 8'($urandom);
  endfunction

  // Extreme high, extreme low, or anything in between.
  function automatic int pick_value(int mode, int lo, int hi);
    if (mode == 1) begin
      return hi;
    end else if (mode == 2) begin
      return lo;
    end
    case ($urandom_range(3))
      0: return lo;
      1: return hi;
      default: return lo + int'($urandom_range(hi - lo));
    endcase
  endfunction

  // Offer one item after a random gap and hold it until it is taken.
  task automatic send_pixel(logic op, logic fs, logic [7:0] c0, logic [7:0] c1,
                            logic [7:0] c2);
    in_item_t px;
    px.op          = op;
    px.frame_start = fs;
    px.chan0       = c0;
    px.chan1       = c1;
    px.chan2       = c2;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
    if (op == OP_MEASURE) begin
      n_measure++;
    end else begin
      n_correct++;
    end
  endtask

  // One register write; the caller lowers cfg_valid after the last of a batch.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
    n_cfg++;
  endtask

  // Stop offering, wait for every expected result, then let the core go quiet.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write every register: mode 0 random, modes 1 and 2 all stages on with high or low extremes.
  task automatic program_cfg(int mode);
    write_reg(CFG_CONTRAST_ENABLE, (mode != 0) || ($urandom_range(3) != 0));
    write_reg(CFG_CONTRAST_GAIN, pick_value(mode, -512, 1023));
    write_reg(CFG_BRIGHTNESS_OFF, pick_value(mode, -255, 255));
    write_reg(CFG_GAMMA_ENABLE, (mode != 0) || ($urandom_range(3) != 0));
    write_reg(CFG_GAMMA_STEP_CH0, pick_value(mode, -64, 64));
    write_reg(CFG_GAMMA_STEP_CH12, pick_value(mode, -32, 32));
    write_reg(CFG_GRAYSCALE_ENABLE, (mode != 0) || ($urandom_range(1) != 0));
    if ($urandom_range(3) == 0) begin
      write_reg(CFG_UNUSED_INDEX, $urandom_range(2047));
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_directed();
    // Reset settings pass pixels through; frame_start on a correct item is ignored.
    send_pixel(OP_CORRECT, 1'b0, 8'd0, 8'd0, 8'd0);
    send_pixel(OP_CORRECT, 1'b1, 8'd255, 8'd255, 8'd255);
    wait_drained();

    // Extreme settings while nothing has been measured, so the mean is zero.
    write_reg(CFG_CONTRAST_ENABLE, 1);
    write_reg(CFG_CONTRAST_GAIN, 1023);
    write_reg(CFG_BRIGHTNESS_OFF, 255);
    write_reg(CFG_GAMMA_ENABLE, 1);
    write_reg(CFG_GAMMA_STEP_CH0, -64);
    write_reg(CFG_GAMMA_STEP_CH12, 32);
    write_reg(CFG_GRAYSCALE_ENABLE, 0);
    write_reg(CFG_UNUSED_INDEX, 2047);
    cfg_valid <= 1'b0;
    send_pixel(OP_CORRECT, 1'b0, 8'd0, 8'd0, 8'd0);
    send_pixel(OP_CORRECT, 1'b0, 8'd255, 8'd128, 8'd1);
    send_pixel(OP_CORRECT, 1'b1, 8'd7, 8'd250, 8'd64);

    // A short frame, then corrections pivoting on its mean.
    send_pixel(OP_MEASURE, 1'b1, 8'd255, 8'd255, 8'd255);
    send_pixel(OP_MEASURE, 1'b0, 8'd0, 8'd255, 8'd0);
    send_pixel(OP_MEASURE, 1'b0, 8'd170, 8'd85, 8'd51);
    send_pixel(OP_CORRECT, 1'b0, 8'd0, 8'd128, 8'd255);
    send_pixel(OP_CORRECT, 1'b0, 8'd255, 8'd255, 8'd255);
    send_pixel(OP_CORRECT, 1'b0, 8'd37, 8'd200, 8'd90);
    wait_drained();

    // Opposite extremes with the grayscale stage on.
    write_reg(CFG_CONTRAST_GAIN, -512);
    write_reg(CFG_BRIGHTNESS_OFF, -255);
    write_reg(CFG_GAMMA_STEP_CH0, 64);
    write_reg(CFG_GAMMA_STEP_CH12, -32);
    write_reg(CFG_GRAYSCALE_ENABLE, 1);
    cfg_valid <= 1'b0;
    send_pixel(OP_CORRECT, 1'b0, 8'd0, 8'd0, 8'd0);
    send_pixel(OP_CORRECT, 1'b0, 8'd255, 8'd255, 8'd255);
    send_pixel(OP_CORRECT, 1'b0, 8'd1, 8'd2, 8'd3);
    send_pixel(OP_CORRECT, 1'b0, 8'd128, 8'd64, 8'd200);

    // A single black pixel measured: a nonzero count with a zero mean.
    send_pixel(OP_MEASURE, 1'b1, 8'd0, 8'd0, 8'd0);
    send_pixel(OP_CORRECT, 1'b0, 8'd100, 8'd100, 8'd100);
  endtask

  // Frames of a measure pass and a correct pass with random content and a little noise.
  task automatic run_frames(int n_items, bit with_hold);
    int sent;
    int n_meas;
    int n_corr;
    bit hold_pending;
    sent         = 0;
    hold_pending = with_hold;
    while (sent < n_items) begin
      n_meas = ($urandom_range(9) == 0) ? $urandom_range(60, 160) : $urandom_range(1, 20);
      for (int k = 0; k < n_meas; k++) begin
        if ($urandom_range(19) == 0) begin
          send_pixel($urandom_range(1) ? OP_CORRECT : OP_MEASURE, 1'($urandom_range(1)),
                     rand_byte(), rand_byte(), rand_byte());
        end else begin
          send_pixel(OP_MEASURE, (k == 0) && ($urandom_range(4) != 0),
                     rand_byte(), rand_byte(), rand_byte());
        end
      end

      // The long hold starts as a long correct pass begins, so the core fills up.
      n_corr = hold_pending ? 60 : $urandom_range(1, 30);
      if (hold_pending) begin
        hold_req     <= hold_req + 1;
        hold_pending = 1'b0;
      end
      for (int k = 0; k < n_corr; k++) begin
        if ($urandom_range(24) == 0) begin
          send_pixel(OP_MEASURE, 1'b0, rand_byte(), rand_byte(), rand_byte());
        end else begin
          send_pixel(OP_CORRECT, 1'($urandom_range(1)), rand_byte(), rand_byte(), rand_byte());
        end
      end
      sent += n_meas + n_corr;
    end
  endtask

  // Main sequence: reset, directed items, then four idling phases of random frames.
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct  = 57;
          stall_pct <= 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct <= 57;
        end
        default: begin
          idle_pct  = 38;
          stall_pct <= 38;
        end
      endcase
      for (int seg = 0; seg < 2; seg++) begin
        wait_drained();
        program_cfg((ph == 0) ? seg + 1 : 0);
        run_frames(205, (ph == 0) && (seg == 0));
      end
    end
    wait_drained();

    $display("Run covered %0d measure and %0d correct items, %0d register writes, %0d results.",
             n_measure, n_correct, n_cfg, results_checked);
    $display("Idling mixes: none, sender only, receiver only, both; one long receiver hold.");
    if (fail_count == 0 && pending_results == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: pixel_contrast_gamma_gray_core.f
hw/rtl/pcg_pkg.sv
hw/rtl/pcg_mean.sv
hw/rtl/pcg_lane.sv
hw/rtl/pcg_merge.sv
hw/rtl/pixel_contrast_gamma_gray_core.sv
tb/pcg_result_checker.sv
tb/testbench.sv
